### hdl/double_round_to_integral_top_assert.svh
// Assertion macros for the round-to-integral block.
`ifndef DOUBLE_ROUND_TO_INTEGRAL_TOP_ASSERT_SVH
`define DOUBLE_ROUND_TO_INTEGRAL_TOP_ASSERT_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define DRI_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dri assertion failed");

// Assert that an antecedent implies a consequent in the next cycle.
`define DRI_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dri assertion failed");

`endif

### hdl/dri_pkg.sv
// ----------------------------------------------------------------------------
// dri_pkg
// Types and constants shared by the round-to-integral block.
// ----------------------------------------------------------------------------
package dri_pkg;

   localparam int unsigned FracWidth = 52;
   localparam logic [63:0] SignBit   = 64'h8000_0000_0000_0000;
   localparam logic [63:0] FracBits  = 64'h000f_ffff_ffff_ffff;
   localparam logic [63:0] OneBits   = 64'h3ff0_0000_0000_0000;
   localparam logic [10:0] ExpBias   = 11'd1023;

   typedef enum logic [1:0] {
      OP_FLOOR = 2'd0,
      OP_CEIL  = 2'd1,
      OP_TRUNC = 2'd2,
      OP_ROUND = 2'd3
   } op_type;

   // Classification of the operand, decided in the second stage.
   typedef enum logic [1:0] {
      CLS_PASS  = 2'd0,
      CLS_SMALL = 2'd1,
      CLS_FRAC  = 2'd2
   } cls_type;

endpackage

### hdl/dri_if.sv
// ----------------------------------------------------------------------------
// dri_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface dri_if #(
   parameter int unsigned WIDTH = 66
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### hdl/double_round_to_integral_top.sv
// Round-to-integral for binary64: a four-stage pipeline from accepted item
// to result valid. Throughput is one item per cycle; a
// stall on the result side freezes all stages together, so no item is
// lost or repeated. Synchronous active-high reset clears the valid bits;
// payload registers are not reset. Ready is high whenever the last stage
// is empty or its item is being taken.
// ----------------------------------------------------------------------------
// double_round_to_integral_top
// Floor, ceil, trunc and round half away from zero on a binary64 pattern.
// ----------------------------------------------------------------------------
module double_round_to_integral_top (
   input logic clock,
   input logic reset,
   dri_if.sink   req,
   dri_if.source rsp
);

   // Stage 1 captures the operand with ceil folded into floor by a sign flip.
   logic        s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic        advance;
   logic [1:0]  s1_op_ff;
   logic [63:0] s1_b_ff;
   logic        s1_flip_ff;
   logic [63:0] s1_b_in;

   // Stage 2: classification and masks.
   logic [1:0]       s2_op_ff;
   logic [63:0]      s2_b_ff, s2_mask_ff, s2_half_ff;
   logic             s2_flip_ff, s2_eminus1_ff;
   dri_pkg::cls_type s2_cls_ff, s2_cls_in;
   logic [63:0]      s2_mask_in, s2_half_in;
   logic [11:0]      e_ext;

   // Stage 3: the add (floor carry or round increment) and truncation.
   logic [63:0]      s3_r_ff, s3_r_in;
   logic             s3_flip_ff;

   logic [63:0]      s4_r_ff;

   logic [1:0]  req_op;
   logic [63:0] req_operand_bits;

   assign req_op           = req.data[65:64];
   assign req_operand_bits = req.data[63:0];

   assign advance   = !s4_vld_ff || rsp.ready;
   assign req.ready = advance;

   always_comb begin
      s1_b_in = req_operand_bits;
      if (dri_pkg::op_type'(req_op) == dri_pkg::OP_CEIL) begin
         s1_b_in = req_operand_bits ^ dri_pkg::SignBit;
      end
   end

   always_comb begin
      e_ext      = {1'b0, s1_b_ff[62:52]} - {1'b0, dri_pkg::ExpBias};
      s2_mask_in = '0;
      s2_half_in = '0;
      if (s1_b_ff[62:52] >= 11'd1075) begin
         s2_cls_in = dri_pkg::CLS_PASS;
      end else if (s1_b_ff[62:52] < dri_pkg::ExpBias) begin
         s2_cls_in = dri_pkg::CLS_SMALL;
      end else begin
         s2_cls_in  = dri_pkg::CLS_FRAC;
         s2_mask_in = dri_pkg::FracBits >> e_ext[5:0];
         s2_half_in = 64'(dri_pkg::FracBits + 64'd1) >> e_ext[5:0];
      end
   end

   always_comb begin
      logic [63:0] b;
      logic        neg;
      logic [63:0] t;
      b   = s2_b_ff;
      neg = b[63];
      t   = b & ~s2_mask_ff;
      s3_r_in = b;
      case (s2_cls_ff)
         dri_pkg::CLS_PASS: begin
            s3_r_in = b;
         end
         dri_pkg::CLS_SMALL: begin
            case (dri_pkg::op_type'(s2_op_ff))
               dri_pkg::OP_FLOOR, dri_pkg::OP_CEIL: begin
                  if (b[62:0] == 63'd0) s3_r_in = b;
                  else if (neg) s3_r_in = dri_pkg::SignBit | dri_pkg::OneBits;
                  else s3_r_in = '0;
               end
               dri_pkg::OP_TRUNC: begin
                  s3_r_in = b & dri_pkg::SignBit;
               end
               default: begin
                  s3_r_in = s2_eminus1_ff ? ((b & dri_pkg::SignBit) | dri_pkg::OneBits)
                                          : (b & dri_pkg::SignBit);
               end
            endcase
         end
         default: begin
            case (dri_pkg::op_type'(s2_op_ff))
               dri_pkg::OP_FLOOR, dri_pkg::OP_CEIL: begin
                  if ((b & s2_mask_ff) == 64'd0) s3_r_in = b;
                  else if (neg) s3_r_in = (b + s2_mask_ff) & ~s2_mask_ff;
                  else s3_r_in = t;
               end
               dri_pkg::OP_TRUNC: begin
                  s3_r_in = t;
               end
               default: begin
                  // The half bit is the top bit of the mask; add one integer unit.
                  s3_r_in = ((b & (s2_mask_ff ^ (s2_mask_ff >> 1))) != 64'd0)
                            ? (t + s2_half_ff) : t;
               end
            endcase
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= req.valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff      <= req_op;
         s1_b_ff       <= s1_b_in;
         s1_flip_ff    <= (dri_pkg::op_type'(req_op) == dri_pkg::OP_CEIL);
         s2_op_ff      <= s1_op_ff;
         s2_b_ff       <= s1_b_ff;
         s2_flip_ff    <= s1_flip_ff;
         s2_cls_ff     <= s2_cls_in;
         s2_mask_ff    <= s2_mask_in;
         s2_half_ff    <= s2_half_in;
         s2_eminus1_ff <= (s1_b_ff[62:52] == 11'd1022);
         s3_r_ff       <= s3_r_in;
         s3_flip_ff    <= s2_flip_ff;
         s4_r_ff       <= s3_flip_ff ? (s3_r_ff ^ dri_pkg::SignBit) : s3_r_ff;
      end
   end

   assign rsp.valid = s4_vld_ff;
   assign rsp.data  = s4_r_ff;

`include "double_round_to_integral_top_assert.svh"

   `DRI_ASSERT_NEXT(a_stall_holds, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.data))
   `DRI_ASSERT_IMPL(a_ready_when_empty, !s4_vld_ff, req.ready)
   `DRI_ASSERT_NEXT(a_valid_moves, advance && s3_vld_ff, s4_vld_ff)

endmodule

### tb/sv/double_round_to_integral_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_round_to_integral_top_test
// Self-checking test of floor, ceil, trunc and round on binary64 patterns.
// Directed corner values, then random operands built around the exponents
// where fraction bits exist, with random gaps on both sides of the pipe.
// Every accepted result is checked against a bit-level predictor.
// ----------------------------------------------------------------------------
module double_round_to_integral_top_test;

   localparam int unsigned CycleLimit = 200000;

   logic clock;
   logic reset;

   dri_if #(.WIDTH(66)) req ();
   dri_if #(.WIDTH(64)) rsp ();

   double_round_to_integral_top DUT (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp)
   );

   logic [63:0] expected_results[$];
   int unsigned mismatch_count;
   int unsigned cycle_count;
   int unsigned stall_left;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Floor on the bits: clear the fraction below the exponent, adding the
   // mask first for a negative value so the carry reaches the integer part.
   function automatic logic [63:0] floor_bits(logic [63:0] b);
      int e;
      logic [63:0] mask;
      e = int'(b[62:52]) - 1023;
      if (e >= 52) return b;
      if (e < 0) begin
         if (b[62:0] == '0) return b;
         return b[63] ? (dri_pkg::SignBit | dri_pkg::OneBits) : 64'd0;
      end
      mask = dri_pkg::FracBits >> e;
      if ((b & mask) == '0) return b;
      if (b[63]) b = b + mask;
      return b & ~mask;
   endfunction

   function automatic logic [63:0] rounded_value(dri_pkg::op_type op, logic [63:0] b);
      int e;
      logic [63:0] t;
      e = int'(b[62:52]) - 1023;
      case (op)
         dri_pkg::OP_FLOOR: return floor_bits(b);
         dri_pkg::OP_CEIL: return floor_bits(b ^ dri_pkg::SignBit) ^ dri_pkg::SignBit;
         dri_pkg::OP_TRUNC: begin
            if (e >= 52) return b;
            if (e < 0) return b & dri_pkg::SignBit;
            return b & ~(dri_pkg::FracBits >> e);
         end
         default: begin
            if (e >= 52) return b;
            if (e == -1) return (b & dri_pkg::SignBit) | dri_pkg::OneBits;
            if (e < 0) return b & dri_pkg::SignBit;
            t = b & ~(dri_pkg::FracBits >> e);
            if (b[51 - e]) t = t + (64'd1 << (52 - e));
            return t;
         end
      endcase
   endfunction

   // Random stalls on the result side: mostly short, now and then long.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 20) begin
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 3);
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result item: %h", rsp.data);
         end else begin
            if (rsp.data !== expected_results[0]) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: expected %h, actual %h",
                           expected_results[0], rsp.data);
            end
            void'(expected_results.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_item(dri_pkg::op_type op, logic [63:0] value);
      int unsigned gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) :
            ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data <= {op, value};
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      expected_results.push_back(rounded_value(op, value));
   endtask

   task automatic test_corner_values();
      logic [63:0] corners[7];
      corners = '{64'h8000_0000_0000_0000,   // negative zero
                  64'hbfe0_0000_0000_0000,   // minus one half
                  64'h3ff8_0000_0000_0000,   // 1.5
                  64'hc004_0000_0000_0000,   // -2.5
                  64'hc32f_ffff_ffff_ffff,   // carry into the exponent
                  64'h7ff8_0000_0000_1234,   // NaN with payload
                  64'h8000_0000_0000_0001};  // smallest negative subnormal
      foreach (corners[i])
         for (int k = 0; k < 4; k++) send_item(dri_pkg::op_type'(k), corners[i]);
      send_item(dri_pkg::OP_ROUND, 64'hfff0_0000_0000_0000);
      send_item(dri_pkg::OP_FLOOR, 64'h3fdf_ffff_ffff_ffff);
   endtask

   function automatic logic [63:0] random_operand();
      logic [10:0] biased;
      logic [51:0] frac;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) return {$urandom, $urandom};
      if (pick < 20) biased = 11'($urandom_range(0, 2047));
      else biased = 11'(32'd1020 + $urandom_range(0, 57));
      frac = 52'({$urandom, $urandom});
      pick = $urandom_range(0, 9);
      // Exact halves and already-integral values are the interesting ties.
      if (pick == 0 && biased >= 1023 && biased < 1075)
         frac = (frac & ~(dri_pkg::FracBits[51:0] >> (biased - 1023)))
                | (52'd1 << (51 - (biased - 1023)));
      else if (pick == 1 && biased >= 1023 && biased < 1075)
         frac = frac & ~(dri_pkg::FracBits[51:0] >> (biased - 1023));
      return {$urandom_range(0, 1) == 1, biased, frac};
   endfunction

   task automatic test_random_operands(int unsigned count);
      for (int unsigned i = 0; i < count; i++)
         send_item(dri_pkg::op_type'($urandom_range(0, 3)), random_operand());
   endtask

   task automatic test_drain_pause();
      req.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b1;
      mismatch_count = 0;
      cycle_count = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_corner_values();
      test_random_operands(260);
      test_drain_pause();
      test_random_operands(260);
      req.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
